// File: rtl/csws_pkg.sv
// Shared types, codes and constants of the clock-set write sequencer.
`default_nettype none
package csws_pkg;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned IN_DATA_W  = 80;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 40;

	localparam logic [2:0] STEP_COUNT = 3'd6;
	localparam logic [2:0] LAST_STEP  = STEP_COUNT - 3'd1;

	localparam logic [31:0] BUSY_BACKOFF_MS = 32'd1000;
	localparam logic [31:0] FAIL_BACKOFF_MS = 32'd5000;

	// register indexes on the config port
	localparam logic [CFG_ADDR_W-1:0] CFG_AUTO_EN     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_SRC_PRESENT = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_BASE_TMO    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_TMO_CAP     = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_RETRY_LIM   = 3'd5;

	localparam logic [15:0] BASE_TMO_RST  = 16'd2000;
	localparam logic [19:0] TMO_CAP_RST   = 20'd16000;
	localparam logic [3:0]  RETRY_LIM_RST = 4'd3;

	typedef enum logic [1:0] {
		OP_REQUEST = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2,
		OP_TICK    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_EXEC  = 2'd1,
		ST_CALC  = 2'd2,
		ST_WRITE = 2'd3
	} state_t;

	// input word, last field in the lowest bits
	typedef struct packed {
		logic [3:0]  pad;
		logic [6:0]  step_tag;
		logic [2:0]  weekday;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic        pending_write;
		logic        clock_valid;
		logic [31:0] now_ms;
	} in_word_t;

	// result word, last field in the lowest bits
	typedef struct packed {
		logic        busy_res;
		logic        aborted;
		logic        sequence_done;
		logic        accepted;
		logic [19:0] command_timeout_ms;
		logic [11:0] command_value;
		logic [2:0]  command_step;
		logic        issue_command;
	} out_word_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic calc;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic issue;
	} dp_sts_t;

	// Sunday 1 .. Saturday 7 -> Sunday 0 .. Saturday 6; 0 maps like 7
	function automatic logic [2:0] weekday_code(input logic [2:0] dow);
		logic [2:0] r;
		case (dow)
			3'd0:    r = 3'd6;
			3'd1:    r = 3'd0;
			3'd2:    r = 3'd1;
			3'd3:    r = 3'd2;
			3'd4:    r = 3'd3;
			3'd5:    r = 3'd4;
			3'd6:    r = 3'd5;
			default: r = 3'd6;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/clock_set_write_sequencer_core.sv
// Top level of the clock-set write sequencer: controller plus datapath.
`default_nettype none
//
// Channel  Dir  Handshake           Payload
// s_       in   s_tvalid/s_tready   s_tuser opcode, s_tdata time fields and step tag
// m_       out  m_tvalid/m_tready   m_tdata command and status word
// cfg_     in   cfg_we              cfg_addr register index, cfg_wdata value
//
// Each word passes capture, update and hand-off; a word that issues a step write
//  also passes the shift-and-cap timeout unit between update and hand-off.
// The output register frees the input side: a new word is taken while the
//  previous result still waits; only a second finished result waits on m_tready.
// Reset clears the controller and the sequence state and loads config defaults;
//  there is no clearing pass.
//
module clock_set_write_sequencer_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// opcode [1:0]
	input  wire [csws_pkg::IN_USER_W-1:0]       s_tuser,
	// now_ms [31:0], clock_valid [32], pending_write [33], year [45:34],
	// month [49:46], day [54:50], hour [59:55], minute [65:60],
	// weekday [68:66], step_tag [75:69], zero [79:76]
	input  wire [csws_pkg::IN_DATA_W-1:0]       s_tdata,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// issue_command [0], command_step [3:1], command_value [15:4],
	// command_timeout_ms [35:16], accepted [36], sequence_done [37],
	// aborted [38], busy_res [39]
	output logic [csws_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	input  wire                                 cfg_we,
	input  wire [csws_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  wire [csws_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import csws_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// state machine: one word at a time, result parked in the output register
	csws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// config, sequence state, timeout unit and result word
	csws_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire

// File: rtl/csws_dp.sv
// Datapath: config registers, sequence state, step decode, timeout unit, result register.
`default_nettype none
module csws_dp (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  csws_pkg::dp_cmd_t                   cmd,
	output csws_pkg::dp_sts_t                   sts,
	input  wire [csws_pkg::IN_DATA_W-1:0]       s_tdata,
	input  wire [csws_pkg::IN_USER_W-1:0]       s_tuser,
	input  wire                                 cfg_we,
	input  wire [csws_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  wire [csws_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output logic [csws_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import csws_pkg::*;

	// config
	logic        auto_en_q;
	logic [31:0] interval_q;
	logic        src_present_q;
	logic [15:0] base_tmo_q;
	logic [19:0] tmo_cap_q;
	logic [3:0]  retry_lim_q;

	// captured word
	in_word_t    iw_q;
	op_t         op_q;

	// sequence state
	logic        inprog_q;
	logic [2:0]  step_q;
	logic [4:0]  retry_q;
	logic [11:0] st_year_q;
	logic [3:0]  st_month_q;
	logic [4:0]  st_day_q;
	logic [4:0]  st_hour_q;
	logic [5:0]  st_minute_q;
	logic [2:0]  st_wday_q;
	logic [31:0] next_sync_q;

	// flags after update, command fields after calc
	logic        issue_s1, accepted_s1, done_s1, aborted_s1;
	logic [2:0]  step_s2;
	logic [11:0] value_s2;
	logic [19:0] tmo_s2;
	out_word_t   out_q;

	// next-state logic
	logic        inprog_nx;
	logic [2:0]  step_nx;
	logic [4:0]  retry_nx;
	logic [4:0]  retry_inc;
	logic        iss, acc, dn, ab;
	logic        start_ok, do_start, tag_ok, tick_gate, sync_upd;
	logic [31:0] sync_inc;
	logic [31:0] next_sync_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_en_q     <= 1'b0;
			interval_q    <= '0;
			src_present_q <= 1'b0;
			base_tmo_q    <= BASE_TMO_RST;
			tmo_cap_q     <= TMO_CAP_RST;
			retry_lim_q   <= RETRY_LIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_AUTO_EN:     auto_en_q     <= cfg_wdata[0];
				CFG_INTERVAL:    interval_q    <= cfg_wdata;
				CFG_SRC_PRESENT: src_present_q <= cfg_wdata[0];
				CFG_BASE_TMO:    base_tmo_q    <= cfg_wdata[15:0];
				CFG_TMO_CAP:     tmo_cap_q     <= cfg_wdata[19:0];
				CFG_RETRY_LIM:   retry_lim_q   <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= '0;
			op_q <= OP_REQUEST;
		end else if (cmd.load_in) begin
			iw_q <= in_word_t'(s_tdata);
			op_q <= op_t'(s_tuser);
		end
	end

	assign retry_inc = retry_q + 5'd1;
	assign tag_ok    = (iw_q.step_tag == ({4'd0, step_q} + 7'd1));
	assign start_ok  = iw_q.clock_valid && !inprog_q && !iw_q.pending_write;
	assign tick_gate = auto_en_q && src_present_q && (interval_q != 32'd0)
		&& (iw_q.now_ms >= next_sync_q);

	always_comb begin
		inprog_nx = inprog_q;
		step_nx   = step_q;
		retry_nx  = retry_q;
		iss       = 1'b0;
		acc       = 1'b0;
		dn        = 1'b0;
		ab        = 1'b0;
		do_start  = 1'b0;
		sync_upd  = 1'b0;
		sync_inc  = BUSY_BACKOFF_MS;
		unique case (op_q)
			OP_REQUEST: do_start = start_ok;
			OP_ACK: begin
				if (inprog_q && tag_ok) begin
					if (step_q == LAST_STEP) begin
						inprog_nx = 1'b0;
						step_nx   = 3'd0;
						retry_nx  = 5'd0;
						dn        = 1'b1;
					end else begin
						step_nx  = step_q + 3'd1;
						retry_nx = 5'd0;
						iss      = 1'b1;
					end
				end
			end
			OP_TIMEOUT: begin
				if (inprog_q) begin
					if (!tag_ok || (retry_inc > {1'b0, retry_lim_q})) begin
						inprog_nx = 1'b0;
						step_nx   = 3'd0;
						retry_nx  = 5'd0;
						ab        = 1'b1;
					end else begin
						retry_nx = retry_inc;
						iss      = 1'b1;
					end
				end
			end
			OP_TICK: begin
				if (tick_gate) begin
					sync_upd = 1'b1;
					if (inprog_q || iw_q.pending_write) begin
						sync_inc = BUSY_BACKOFF_MS;
					end else if (iw_q.clock_valid) begin
						do_start = 1'b1;
						sync_inc = interval_q;
					end else begin
						sync_inc = FAIL_BACKOFF_MS;
					end
				end
			end
		endcase
		if (do_start) begin
			inprog_nx = 1'b1;
			step_nx   = 3'd0;
			retry_nx  = 5'd0;
			iss       = 1'b1;
			acc       = 1'b1;
		end
		next_sync_nx = sync_upd ? (iw_q.now_ms + sync_inc) : next_sync_q;
	end

	assign sts.issue = iss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inprog_q    <= 1'b0;
			step_q      <= 3'd0;
			retry_q     <= 5'd0;
			st_year_q   <= 12'd0;
			st_month_q  <= 4'd1;
			st_day_q    <= 5'd1;
			st_hour_q   <= 5'd0;
			st_minute_q <= 6'd0;
			st_wday_q   <= 3'd0;
			next_sync_q <= '0;
			issue_s1    <= 1'b0;
			accepted_s1 <= 1'b0;
			done_s1     <= 1'b0;
			aborted_s1  <= 1'b0;
		end else if (cmd.exec) begin
			inprog_q    <= inprog_nx;
			step_q      <= step_nx;
			retry_q     <= retry_nx;
			next_sync_q <= next_sync_nx;
			issue_s1    <= iss;
			accepted_s1 <= acc;
			done_s1     <= dn;
			aborted_s1  <= ab;
			if (do_start) begin
				st_year_q   <= iw_q.year;
				st_month_q  <= iw_q.month;
				st_day_q    <= iw_q.day;
				st_hour_q   <= iw_q.hour;
				st_minute_q <= iw_q.minute;
				st_wday_q   <= iw_q.weekday;
			end
		end
	end

	// timeout: base doubled per retry, cap once any doubling passes it
	logic [47:0] tmo_shift;
	logic        tmo_over;
	logic [19:0] tmo_val;
	logic [11:0] step_val;

	assign tmo_shift = {32'd0, base_tmo_q} << retry_q;
	assign tmo_over  = (tmo_shift > {28'd0, tmo_cap_q});
	assign tmo_val   = (retry_q == 5'd0) ? {4'd0, base_tmo_q}
		: (tmo_over ? tmo_cap_q : tmo_shift[19:0]);

	always_comb begin
		case (step_q)
			3'd0:    step_val = st_year_q;
			3'd1:    step_val = {8'd0, st_month_q};
			3'd2:    step_val = {7'd0, st_day_q};
			3'd3:    step_val = {7'd0, st_hour_q};
			3'd4:    step_val = {6'd0, st_minute_q};
			default: step_val = {9'd0, weekday_code(st_wday_q)};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			step_s2  <= step_q + 3'd1;
			value_s2 <= step_val;
			tmo_s2   <= tmo_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.issue_command      <= issue_s1;
			out_q.command_step       <= issue_s1 ? step_s2 : 3'd0;
			out_q.command_value      <= issue_s1 ? value_s2 : 12'd0;
			out_q.command_timeout_ms <= issue_s1 ? tmo_s2 : 20'd0;
			out_q.accepted           <= accepted_s1;
			out_q.sequence_done      <= done_s1;
			out_q.aborted            <= aborted_s1;
			out_q.busy_res           <= inprog_q;
		end
	end

	assign m_tdata = out_q;

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!inprog_q |-> (step_q == 3'd0 && retry_q == 5'd0))
		else $error("idle with step or retry state left over");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= LAST_STEP)
		else $error("step index beyond last step");

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({issue_s1, done_s1, aborted_s1}) && (!accepted_s1 || issue_s1))
		else $error("conflicting outcome flags");

endmodule
`default_nettype wire

// File: rtl/csws_ctrl.sv
// Controller: sequences capture, update, timeout calculation and result hand-off.
`default_nettype none
module csws_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output csws_pkg::dp_cmd_t   cmd,
	input  csws_pkg::dp_sts_t   sts
);
	import csws_pkg::*;

	state_t state_q, state_nx;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_nx = ST_EXEC;
			ST_EXEC:  state_nx = sts.issue ? ST_CALC : ST_WRITE;
			ST_CALC:  state_nx = ST_WRITE;
			ST_WRITE: if (out_free) state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_EXEC:  cmd.exec = 1'b1;
			ST_CALC:  cmd.calc = 1'b1;
			ST_WRITE: cmd.load_out = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_EXEC))
		else $error("accepted word not followed by update");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_WRITE))
		else $error("result raised outside write state");

	a_calc_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> ($past(state_q) == ST_EXEC))
		else $error("timeout calculation entered without update");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid_q || m_tready))
		else $error("pending result overwritten");

endmodule
`default_nettype wire

// File: verif/clock_set_write_sequencer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the clock-set write sequencer: directed cases, then random phases.
module clock_set_write_sequencer_core_tb;
	import csws_pkg::*;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 240;

	// Register set loaded between phases.
	typedef struct {
		logic        auto_en;
		logic [31:0] sync_period;
		logic        src_present;
		logic [15:0] base_tmo;
		logic [19:0] tmo_cap;
		logic [3:0]  retry_lim;
	} reg_set_t;

	// Mirror of the sequencer: its registers, its sequence state and the
	// result words still owed by the block, oldest first.
	class time_write_checker;
		logic        auto_en;
		logic [31:0] sync_period;
		logic        src_present;
		logic [15:0] base_tmo;
		logic [19:0] tmo_cap;
		logic [3:0]  retry_lim;

		logic        busy;
		logic [2:0]  seq_step;   // 0 year .. 5 weekday
		logic [4:0]  retries;
		logic [11:0] year_q;
		logic [3:0]  month_q;
		logic [4:0]  day_q;
		logic [4:0]  hour_q;
		logic [5:0]  minute_q;
		logic [2:0]  dow_q;
		logic [31:0] next_sync_ms;

		out_word_t   owed_results[$];
		int unsigned mismatches;

		function new();
			auto_en      = 1'b0;
			sync_period  = '0;
			src_present  = 1'b0;
			base_tmo     = BASE_TMO_RST;
			tmo_cap      = TMO_CAP_RST;
			retry_lim    = RETRY_LIM_RST;
			busy         = 1'b0;
			seq_step     = '0;
			retries      = '0;
			year_q       = '0;
			month_q      = 4'd1;
			day_q        = 5'd1;
			hour_q       = '0;
			minute_q     = '0;
			dow_q        = '0;
			next_sync_ms = '0;
			mismatches   = 0;
		endfunction

		function void set_reg(input logic [CFG_ADDR_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_AUTO_EN:     auto_en     = val[0];
				CFG_INTERVAL:    sync_period = val;
				CFG_SRC_PRESENT: src_present = val[0];
				CFG_BASE_TMO:    base_tmo    = val[15:0];
				CFG_TMO_CAP:     tmo_cap     = val[19:0];
				CFG_RETRY_LIM:   retry_lim   = val[3:0];
				default: ;
			endcase
		endfunction

		// base doubled once per retry so far; the first doubling past the cap
		// takes the cap and stops
		function logic [19:0] cur_timeout();
			logic [63:0] t;
			int          i;
			t = 64'(base_tmo);
			for (i = 0; i < int'(retries); i++) begin
				t = t << 1;
				if (t > 64'(tmo_cap)) begin
					t = 64'(tmo_cap);
					break;
				end
			end
			return t[19:0];
		endfunction

		function logic [11:0] cur_value();
			case (seq_step)
				3'd0:    return year_q;
				3'd1:    return 12'(month_q);
				3'd2:    return 12'(day_q);
				3'd3:    return 12'(hour_q);
				3'd4:    return 12'(minute_q);
				default: return 12'(((int'(dow_q) % 7) + 6) % 7);
			endcase
		endfunction

		function void issue(inout out_word_t r);
			r.issue_command      = 1'b1;
			r.command_step       = seq_step + 3'd1;
			r.command_value      = cur_value();
			r.command_timeout_ms = cur_timeout();
		endfunction

		function void abandon(inout out_word_t r);
			busy      = 1'b0;
			seq_step  = '0;
			retries   = '0;
			r.aborted = 1'b1;
		endfunction

		function bit try_start(input in_word_t w, inout out_word_t r);
			if (!w.clock_valid || busy || w.pending_write)
				return 1'b0;
			year_q   = w.year;
			month_q  = w.month;
			day_q    = w.day;
			hour_q   = w.hour;
			minute_q = w.minute;
			dow_q    = w.weekday;
			busy     = 1'b1;
			seq_step = '0;
			retries  = '0;
			issue(r);
			r.accepted = 1'b1;
			return 1'b1;
		endfunction

		// Works out the result of one accepted word and queues it.
		function void predict_command(input op_t op, input in_word_t w);
			out_word_t r;
			int        tag;
			r   = '0;
			tag = int'(w.step_tag);
			case (op)
				OP_REQUEST: void'(try_start(w, r));
				OP_ACK: begin
					if (busy && tag == int'(seq_step) + 1) begin
						if (seq_step == LAST_STEP) begin
							busy            = 1'b0;
							seq_step        = '0;
							retries         = '0;
							r.sequence_done = 1'b1;
						end else begin
							retries  = '0;
							seq_step = seq_step + 3'd1;
							issue(r);
						end
					end
				end
				OP_TIMEOUT: begin
					if (busy) begin
						if (tag != int'(seq_step) + 1) begin
							abandon(r);
						end else begin
							retries = retries + 5'd1;
							if (retries > 5'(retry_lim))
								abandon(r);
							else
								issue(r);
						end
					end
				end
				OP_TICK: begin
					if (auto_en && src_present && sync_period != 0
						&& w.now_ms >= next_sync_ms) begin
						if (busy || w.pending_write)
							next_sync_ms = w.now_ms + BUSY_BACKOFF_MS;
						else if (try_start(w, r))
							next_sync_ms = w.now_ms + sync_period;
						else
							next_sync_ms = w.now_ms + FAIL_BACKOFF_MS;
					end
				end
				default: ;
			endcase
			r.busy_res = busy;
			owed_results.push_back(r);
		endfunction

		function void cmp(input string name, input logic [31:0] e, input logic [31:0] a);
			if (e !== a) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, e, a);
				mismatches++;
			end
		endfunction

		function void check_command(input out_word_t got);
			out_word_t want;
			if (owed_results.size() == 0) begin
				$display("%0t: result word with none owed, expected none actual %h", $time, got);
				mismatches++;
				return;
			end
			want = owed_results.pop_front();
			cmp("issue_command", 32'(want.issue_command), 32'(got.issue_command));
			cmp("command_step", 32'(want.command_step), 32'(got.command_step));
			cmp("command_value", 32'(want.command_value), 32'(got.command_value));
			cmp("command_timeout_ms", 32'(want.command_timeout_ms),
				32'(got.command_timeout_ms));
			cmp("accepted", 32'(want.accepted), 32'(got.accepted));
			cmp("sequence_done", 32'(want.sequence_done), 32'(got.sequence_done));
			cmp("aborted", 32'(want.aborted), 32'(got.aborted));
			cmp("busy_res", 32'(want.busy_res), 32'(got.busy_res));
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic [IN_USER_W-1:0]  s_tuser   = '0;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	time_write_checker chk = new();

	// sender pacing and the running millisecond counter fed to ticks
	bit          gaps_on    = 1'b1;
	int unsigned burst_left = 4;
	logic [31:0] clock_ms   = '0;

	// receiver cycle counter and stall pattern, the pattern re-picked at random periodically
	int unsigned rx_cycle = 0;
	int unsigned rx_mode  = 0;

	clock_set_write_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: always ready, random stalls, a long stall run, or a short
	// regular one. Mode 0 gives the stretches with no back-pressure.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 300 == 0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= ($urandom_range(0, 3) != 0);
			2:       m_tready <= (rx_cycle % 11) < 4;
			default: m_tready <= (rx_cycle % 3) != 0;
		endcase
	end

	// Result side: every word taken is checked against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			chk.check_command(out_word_t'(m_tdata));
	end

	// Present one word, hold it until taken, predict it, then maybe gap.
	task automatic send_word(input op_t op, input in_word_t w);
		s_tuser  <= op;
		s_tdata  <= w;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		chk.predict_command(op, w);
		if (gaps_on) begin
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst_left = $urandom_range(1, 16);
			end
		end
	endtask

	// Stop sending until every owed word has come back, plus a margin.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (chk.owed_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		chk.set_reg(idx, val);
	endtask

	task automatic load_regs(input reg_set_t rs);
		write_reg(CFG_AUTO_EN, 32'(rs.auto_en));
		write_reg(CFG_INTERVAL, rs.sync_period);
		write_reg(CFG_SRC_PRESENT, 32'(rs.src_present));
		write_reg(CFG_BASE_TMO, 32'(rs.base_tmo));
		write_reg(CFG_TMO_CAP, 32'(rs.tmo_cap));
		write_reg(CFG_RETRY_LIM, 32'(rs.retry_lim));
		cfg_we <= 1'b0;
	endtask

	// Fixed settings first (defaults-like, all maxima, all minima, auto off,
	// no source, zero interval), then random ones.
	function automatic reg_set_t phase_regs(input int ph);
		reg_set_t r;
		case (ph)
			0: r = '{1'b1, 32'd3000, 1'b1, 16'd2000, 20'd16000, 4'd3};
			1: r = '{1'b1, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 20'hF_FFFF, 4'hF};
			2: r = '{1'b1, 32'd1, 1'b1, 16'd1, 20'd1, 4'd0};
			3: r = '{1'b0, 32'd0, 1'b0, 16'd700, 20'd900, 4'd2};
			4: r = '{1'b1, 32'd500, 1'b0, 16'd40000, 20'd100, 4'd5};
			5: r = '{1'b1, 32'd0, 1'b1, 16'd300, 20'd65535, 4'd1};
			default: begin
				r.auto_en     = ($urandom_range(0, 3) != 0);
				r.sync_period = ($urandom_range(0, 3) == 0) ? $urandom
					: $urandom_range(1, 6000);
				r.src_present = ($urandom_range(0, 3) != 0);
				r.base_tmo    = 16'($urandom_range(1, 65535));
				r.tmo_cap     = 20'($urandom_range(1, 20'hF_FFFF));
				r.retry_lim   = 4'($urandom_range(0, 15));
			end
		endcase
		return r;
	endfunction

	// Random word shaped by the mirrored state: while a sequence runs, mostly
	// acks and timeouts for the current step; while idle, mostly requests and ticks.
	task automatic pick_word(output op_t op, output in_word_t w);
		int roll;
		w = '0;
		if ($urandom_range(0, 3) != 0) begin
			w.year    = 12'($urandom_range(1970, 2100));
			w.month   = 4'($urandom_range(1, 12));
			w.day     = 5'($urandom_range(1, 31));
			w.hour    = 5'($urandom_range(0, 23));
			w.minute  = 6'($urandom_range(0, 59));
			w.weekday = 3'($urandom_range(1, 7));
		end else begin
			w.year    = 12'($urandom);
			w.month   = 4'($urandom);
			w.day     = 5'($urandom);
			w.hour    = 5'($urandom);
			w.minute  = 6'($urandom);
			w.weekday = 3'($urandom);
		end
		// ms counter creeps forward, now and then jumps anywhere or near the wrap
		clock_ms = clock_ms + $urandom_range(0, 2500);
		roll = $urandom_range(0, 99);
		if (roll == 0)
			clock_ms = $urandom;
		else if (roll == 1)
			clock_ms = 32'hFFFF_F000 + $urandom_range(0, 4000);
		w.now_ms        = clock_ms;
		w.clock_valid   = ($urandom_range(0, 9) != 0);
		w.pending_write = ($urandom_range(0, 7) == 0);
		w.step_tag      = 7'(chk.seq_step) + 7'd1;
		roll = $urandom_range(0, 99);
		if (chk.busy) begin
			if (roll < 60) begin
				op = OP_ACK;
			end else if (roll < 80) begin
				op = OP_TIMEOUT;
			end else if (roll < 90) begin
				op = (roll < 85) ? OP_ACK : OP_TIMEOUT;
				w.step_tag = 7'($urandom);
			end else if (roll < 95) begin
				op = OP_REQUEST;
			end else begin
				op = OP_TICK;
			end
		end else begin
			if (roll < 50) begin
				op = OP_REQUEST;
			end else if (roll < 85) begin
				op = OP_TICK;
			end else begin
				op = (roll < 92) ? OP_ACK : OP_TIMEOUT;
				w.step_tag = 7'($urandom);
			end
		end
	endtask

	initial begin : stimulus
		in_word_t    w;
		op_t         op;
		int unsigned counted;
		int          ph;
		int          s;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// ---- directed part, reset register values ----
		w = '0;
		w.clock_valid = 1'b1;
		w.year        = 12'd2024;
		w.month       = 4'd6;
		w.day         = 5'd15;
		w.hour        = 5'd12;
		w.minute      = 6'd30;
		w.weekday     = 3'd4;
		w.step_tag    = 7'd1;
		send_word(OP_ACK, w);         // ack while idle: ignored
		send_word(OP_TIMEOUT, w);     // timeout while idle: ignored
		w.clock_valid = 1'b0;
		send_word(OP_REQUEST, w);     // refused, clock not valid
		w.clock_valid   = 1'b1;
		w.pending_write = 1'b1;
		send_word(OP_REQUEST, w);     // refused, write already queued
		w.pending_write = 1'b0;

		// every field at its top value, weekday 7 maps to Saturday
		w.year    = 12'hFFF;
		w.month   = 4'hF;
		w.day     = 5'h1F;
		w.hour    = 5'h1F;
		w.minute  = 6'h3F;
		w.weekday = 3'h7;
		w.now_ms  = 32'hFFFF_FFFF;
		send_word(OP_REQUEST, w);     // accepted, step 1
		send_word(OP_REQUEST, w);     // refused, busy
		w.step_tag = 7'd2;
		send_word(OP_ACK, w);         // ack for another step: ignored
		for (s = 1; s <= 6; s++) begin
			w.step_tag = 7'(s);
			send_word(OP_ACK, w);     // steps 2..6, then done
		end

		// all fields zero, weekday 0 treated like 7
		w = '0;
		w.clock_valid = 1'b1;
		send_word(OP_REQUEST, w);
		w.step_tag = 7'd1;
		repeat (4) send_word(OP_TIMEOUT, w);   // three retries, then abort

		// timeout with unparseable tag, tag past the last step, other step
		w.weekday = 3'd1;
		send_word(OP_REQUEST, w);
		w.step_tag = 7'd0;
		send_word(OP_TIMEOUT, w);
		send_word(OP_REQUEST, w);
		w.step_tag = 7'd7;
		send_word(OP_TIMEOUT, w);
		send_word(OP_REQUEST, w);
		w.step_tag = 7'h7F;
		send_word(OP_ACK, w);         // ignored
		w.step_tag = 7'd3;
		send_word(OP_TIMEOUT, w);     // other step: abort
		send_word(OP_TICK, w);        // auto sync off: ignored
		drain();

		// ---- random phases, registers reloaded while idle ----
		for (ph = 0; ph < PHASES; ph++) begin
			load_regs(phase_regs(ph));
			gaps_on    = (ph % 3) != 1;
			burst_left = $urandom_range(1, 16);
			counted    = 0;
			while (counted < ITEMS_PER_PHASE) begin
				pick_word(op, w);
				send_word(op, w);
				counted++;
				// now and then hold off until the block has caught up
				if ($urandom_range(0, 149) == 0)
					drain();
			end
			drain();
		end

		repeat (16) @(posedge clk);
		if (chk.mismatches == 0 && chk.owed_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
